// ===== sv/qea_pkg.sv =====
`default_nettype none

package qea_pkg;

    typedef enum logic [0:0] {
        OP_SAMPLE  = 1'b0,
        OP_CONSUME = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // Control that travels with an item from stage to stage
    typedef struct packed {
        logic valid;
        op_t  op;
        dir_t dir;
    } stage_ctrl_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int RATE_W      = 10;
    localparam int STEP_MAG_W  = 17;
    localparam int STEP_W      = 18;
    localparam int DELTA_W     = 32;
    localparam int TIME_W      = 32;
    localparam int DT_W        = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_RATE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_RATE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_STEP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEDIUM_STEP = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_STEP   = 3'd4;

    localparam logic [RATE_W-1:0]     FAST_RATE_RESET   = 10'd20;
    localparam logic [RATE_W-1:0]     MEDIUM_RATE_RESET = 10'd8;
    localparam logic [STEP_MAG_W-1:0] SLOW_STEP_RESET   = 17'd100;
    localparam logic [STEP_MAG_W-1:0] MEDIUM_STEP_RESET = 17'd500;
    localparam logic [STEP_MAG_W-1:0] FAST_STEP_RESET   = 17'd1000;

    localparam logic [1:0] PINS_RESET = 2'b11;

    // Transition table indexed by {previous A, previous B, new A, new B}
    function automatic dir_t dir_lookup(input logic [3:0] trans);
        dir_t d;
        case (trans)
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_DOWN;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_UP;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/qea_sample_if.sv =====
`default_nettype none

interface qea_sample_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic        pin_a;
    logic        pin_b;
    logic [31:0] now_ms;

    modport source (output valid, op, pin_a, pin_b, now_ms, input ready);
    modport sink   (input valid, op, pin_a, pin_b, now_ms, output ready);
endinterface

`default_nettype wire

// ===== sv/qea_result_if.sv =====
`default_nettype none

interface qea_result_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] step_mg;
    logic signed [31:0] delta_mg;

    modport source (output valid, step_mg, delta_mg, input ready);
    modport sink   (input valid, step_mg, delta_mg, output ready);
endinterface

`default_nettype wire

// ===== sv/qea_interval.sv =====
`default_nettype none

module qea_interval #(
    parameter int INTERVAL_FRAC_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire qea_pkg::op_t                        in_op,
    input  wire logic                                pin_a,
    input  wire logic                                pin_b,
    input  wire logic [qea_pkg::TIME_W-1:0]          now_ms,
    output qea_pkg::stage_ctrl_t                     ctrl,
    output logic [16+INTERVAL_FRAC_BITS-1:0]         avg
);

    localparam int AW = 16 + INTERVAL_FRAC_BITS;
    localparam int MW = AW + 4;
    localparam int K  = MW + 4;
    localparam int PW = 2 * MW + 1;
    localparam logic [63:0] RECIP = ((64'd1 << K) + 64'd9) / 64'd10;
    localparam logic [AW-1:0] AVG_MAX = {16'hFFFF, {INTERVAL_FRAC_BITS{1'b0}}};

    logic                         a_valid_reg;
    qea_pkg::op_t                 a_op_reg;
    logic [1:0]                   a_pins_reg;
    logic [qea_pkg::TIME_W-1:0]   a_now_reg;

    logic [1:0]                   prev_pins_reg, prev_pins_next;
    logic [qea_pkg::TIME_W-1:0]   last_time_reg, last_time_next;
    logic [AW-1:0]                avg_reg, avg_next;
    qea_pkg::stage_ctrl_t         ctrl_reg, ctrl_next;

    qea_pkg::dir_t                dir;
    logic                         is_sample;
    logic                         step_taken;
    logic [qea_pkg::TIME_W-1:0]   elapsed;
    logic [qea_pkg::DT_W-1:0]     dt;
    logic [AW-1:0]                dt_scaled;
    logic [MW-1:0]                mix;
    logic [PW-1:0]                prod;
    logic [AW:0]                  quot;

    always_comb
    begin
        dir        = qea_pkg::dir_lookup({prev_pins_reg, a_pins_reg});
        is_sample  = a_valid_reg && (a_op_reg == qea_pkg::OP_SAMPLE);
        step_taken = is_sample && (dir != qea_pkg::DIR_NONE);

        // floor at 1 ms, saturate at 65535 ms
        elapsed = a_now_reg - last_time_reg;
        if (elapsed == '0)
            dt = qea_pkg::DT_W'(1);
        else if (elapsed[qea_pkg::TIME_W-1:qea_pkg::DT_W] != '0)
            dt = '1;
        else
            dt = elapsed[qea_pkg::DT_W-1:0];
        dt_scaled = {dt, {INTERVAL_FRAC_BITS{1'b0}}};

        // (7*old + 3*new + 5) / 10, division by reciprocal multiply
        mix  = (MW'(avg_reg) << 3) - MW'(avg_reg)
             + (MW'(dt_scaled) << 1) + MW'(dt_scaled) + MW'(5);
        prod = PW'(mix) * PW'(RECIP);
        quot = prod[K +: AW+1];

        prev_pins_next = prev_pins_reg;
        last_time_next = last_time_reg;
        avg_next       = avg_reg;
        if (is_sample)
            prev_pins_next = a_pins_reg;
        if (step_taken)
        begin
            last_time_next = a_now_reg;
            avg_next = (quot > {1'b0, AVG_MAX}) ? AVG_MAX : quot[AW-1:0];
        end

        ctrl_next.valid = a_valid_reg;
        ctrl_next.op    = a_op_reg;
        ctrl_next.dir   = is_sample ? dir : qea_pkg::DIR_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            prev_pins_reg <= qea_pkg::PINS_RESET;
            last_time_reg <= '0;
            avg_reg       <= '0;
            ctrl_reg      <= '0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            prev_pins_reg <= prev_pins_next;
            last_time_reg <= last_time_next;
            avg_reg       <= avg_next;
            ctrl_reg      <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_op_reg   <= in_op;
            a_pins_reg <= {pin_a, pin_b};
            a_now_reg  <= now_ms;
        end
    end

    assign ctrl = ctrl_reg;
    assign avg  = avg_reg;

    assert property (@(posedge clk) disable iff (!rst_n) avg_reg <= AVG_MAX)
        else $error("average interval above its ceiling");

    assert property (@(posedge clk) disable iff (!rst_n)
        (en && step_taken) |=> (last_time_reg == $past(a_now_reg)))
        else $error("step time not recorded");

endmodule

`default_nettype wire

// ===== sv/qea_rate.sv =====
`default_nettype none

module qea_rate #(
    parameter int INTERVAL_FRAC_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire qea_pkg::stage_ctrl_t                ctrl_in,
    input  wire logic [16+INTERVAL_FRAC_BITS-1:0]    avg,
    input  wire logic [qea_pkg::RATE_W-1:0]          fast_rate_threshold,
    input  wire logic [qea_pkg::RATE_W-1:0]          medium_rate_threshold,
    output qea_pkg::stage_ctrl_t                     ctrl_out,
    output logic                                     fast_above,
    output logic                                     medium_above
);

    localparam int AW = 16 + INTERVAL_FRAC_BITS;
    localparam int PW = AW + qea_pkg::RATE_W;

    logic [PW-1:0]        lhs;
    logic [PW-1:0]        fast_prod, medium_prod;
    qea_pkg::stage_ctrl_t ctrl_reg;
    logic                 fast_reg, fast_next;
    logic                 medium_reg, medium_next;

    // rate above T  <=>  (1000 << frac) > T * average
    always_comb
    begin
        lhs         = PW'(1000) << INTERVAL_FRAC_BITS;
        fast_prod   = PW'(fast_rate_threshold) * PW'(avg);
        medium_prod = PW'(medium_rate_threshold) * PW'(avg);
        fast_next   = lhs > fast_prod;
        medium_next = lhs > medium_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fast_reg   <= fast_next;
            medium_reg <= medium_next;
        end
    end

    assign ctrl_out     = ctrl_reg;
    assign fast_above   = fast_reg;
    assign medium_above = medium_reg;

endmodule

`default_nettype wire

// ===== sv/qea_accum.sv =====
`default_nettype none

module qea_accum (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire qea_pkg::stage_ctrl_t                ctrl,
    input  wire logic                                fast_above,
    input  wire logic                                medium_above,
    input  wire logic [qea_pkg::STEP_MAG_W-1:0]      slow_step_mg,
    input  wire logic [qea_pkg::STEP_MAG_W-1:0]      medium_step_mg,
    input  wire logic [qea_pkg::STEP_MAG_W-1:0]      fast_step_mg,
    qea_result_if.source                             result_out
);

    logic                                 valid_reg;
    logic signed [qea_pkg::STEP_W-1:0]    step_reg, step_next;
    logic signed [qea_pkg::DELTA_W-1:0]   delta_reg, delta_next;
    logic signed [qea_pkg::DELTA_W-1:0]   acc_reg, acc_next;

    logic [qea_pkg::STEP_MAG_W-1:0]       mag;
    logic signed [qea_pkg::STEP_W-1:0]    mag_s;
    logic signed [qea_pkg::DELTA_W:0]     sum;

    always_comb
    begin
        if (fast_above)
            mag = fast_step_mg;
        else if (medium_above)
            mag = medium_step_mg;
        else
            mag = slow_step_mg;
        mag_s = $signed({1'b0, mag});

        case (ctrl.dir)
            qea_pkg::DIR_UP:   step_next = mag_s;
            qea_pkg::DIR_DOWN: step_next = -mag_s;
            default:           step_next = '0;
        endcase

        sum = (qea_pkg::DELTA_W+1)'(acc_reg) + (qea_pkg::DELTA_W+1)'(step_next);

        delta_next = '0;
        acc_next   = acc_reg;
        if (ctrl.valid)
        begin
            if (ctrl.op == qea_pkg::OP_CONSUME)
            begin
                delta_next = acc_reg;
                acc_next   = '0;
                step_next  = '0;
            end
            else if (sum[qea_pkg::DELTA_W] != sum[qea_pkg::DELTA_W-1])
                // saturate toward the sign of the true sum
                acc_next = sum[qea_pkg::DELTA_W] ? {1'b1, {(qea_pkg::DELTA_W-1){1'b0}}}
                                                 : {1'b0, {(qea_pkg::DELTA_W-1){1'b1}}};
            else
                acc_next = sum[qea_pkg::DELTA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else if (en)
        begin
            valid_reg <= ctrl.valid;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg  <= step_next;
            delta_reg <= delta_next;
        end
    end

    assign result_out.valid    = valid_reg;
    assign result_out.step_mg  = step_reg;
    assign result_out.delta_mg = delta_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (step_reg == '0 || delta_reg == '0))
        else $error("result carries both a step and a delta");

    assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctrl.valid && ctrl.op == qea_pkg::OP_CONSUME) |=> (acc_reg == '0))
        else $error("accumulator not cleared by consume");

endmodule

`default_nettype wire

// ===== sv/quadrature_encoder_with_acceleration_top.sv =====
// Path: an input transfer passes through the input register, interval average,
//   rate compare and result register before its result is valid.
// Throughput: one item per cycle; the whole pipeline holds while a finished
//   result waits for its transfer, and only then.
// Reset: asynchronous, active low; pins read as both high, step time,
//   average and accumulator clear, registers return to 20, 8, 100, 500, 1000.
`default_nettype none

module quadrature_encoder_with_acceleration_top #(
    parameter int INTERVAL_FRAC_BITS = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    qea_sample_if.sink                                 sample_in,
    qea_result_if.source                               result_out,
    input  wire logic                                  cfg_we,
    input  wire logic [qea_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [qea_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // Configuration registers; user writes only when pipeline empty, unchecked
    logic [qea_pkg::RATE_W-1:0]     fast_rate_reg;
    logic [qea_pkg::RATE_W-1:0]     medium_rate_reg;
    logic [qea_pkg::STEP_MAG_W-1:0] slow_step_reg;
    logic [qea_pkg::STEP_MAG_W-1:0] medium_step_reg;
    logic [qea_pkg::STEP_MAG_W-1:0] fast_step_reg;

    // One enable for every stage: advance unless the result register is
    // full and its transfer is not happening this cycle.
    logic pipe_en;

    qea_pkg::stage_ctrl_t                  interval_ctrl;
    logic [16+INTERVAL_FRAC_BITS-1:0]      interval_avg;
    qea_pkg::stage_ctrl_t                  rate_ctrl;
    logic                                  fast_above;
    logic                                  medium_above;

    assign pipe_en         = !result_out.valid || result_out.ready;
    assign sample_in.ready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_rate_reg   <= qea_pkg::FAST_RATE_RESET;
            medium_rate_reg <= qea_pkg::MEDIUM_RATE_RESET;
            slow_step_reg   <= qea_pkg::SLOW_STEP_RESET;
            medium_step_reg <= qea_pkg::MEDIUM_STEP_RESET;
            fast_step_reg   <= qea_pkg::FAST_STEP_RESET;
        end
        else if (cfg_we)
        begin
            // rate thresholds keep the low bits only; unknown indexes drop
            case (cfg_index)
                qea_pkg::CFG_FAST_RATE:   fast_rate_reg   <= cfg_data[qea_pkg::RATE_W-1:0];
                qea_pkg::CFG_MEDIUM_RATE: medium_rate_reg <= cfg_data[qea_pkg::RATE_W-1:0];
                qea_pkg::CFG_SLOW_STEP:   slow_step_reg   <= cfg_data;
                qea_pkg::CFG_MEDIUM_STEP: medium_step_reg <= cfg_data;
                qea_pkg::CFG_FAST_STEP:   fast_step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: input register, direction decode, interval and average update.
    // The average recurrence closes in this stage so a step may follow a step
    // on the very next cycle.
    qea_interval #(
        .INTERVAL_FRAC_BITS (INTERVAL_FRAC_BITS)
    ) u_interval (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_valid (sample_in.valid),
        .in_op    (qea_pkg::op_t'(sample_in.op)),
        .pin_a    (sample_in.pin_a),
        .pin_b    (sample_in.pin_b),
        .now_ms   (sample_in.now_ms),
        .ctrl     (interval_ctrl),
        .avg      (interval_avg)
    );

    // Stage 2: two threshold products against the freshly updated average.
    qea_rate #(
        .INTERVAL_FRAC_BITS (INTERVAL_FRAC_BITS)
    ) u_rate (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .en                    (pipe_en),
        .ctrl_in               (interval_ctrl),
        .avg                   (interval_avg),
        .fast_rate_threshold   (fast_rate_reg),
        .medium_rate_threshold (medium_rate_reg),
        .ctrl_out              (rate_ctrl),
        .fast_above            (fast_above),
        .medium_above          (medium_above)
    );

    // Stage 3: pick the step size, saturating accumulate or consume, and
    // hold the result until its transfer.
    qea_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (pipe_en),
        .ctrl           (rate_ctrl),
        .fast_above     (fast_above),
        .medium_above   (medium_above),
        .slow_step_mg   (slow_step_reg),
        .medium_step_mg (medium_step_reg),
        .fast_step_mg   (fast_step_reg),
        .result_out     (result_out)
    );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
    import qea_pkg::*;

    localparam int  INTERVAL_FRAC    = 8;
    localparam int  LONG_HOLD_AT     = 140;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam int  MAX_REPORTS      = 10;
    localparam longint AVG_CEIL      = longint'(65535) << INTERVAL_FRAC;
    localparam logic [CFG_DATA_W-1:0] MG_ALL_ONES = '1;

    typedef struct {
        op_t         op;
        logic        pin_a;
        logic        pin_b;
        logic [31:0] now_ms;
    } encoder_sample_t;

    typedef struct {
        logic signed [STEP_W-1:0]  step_mg;
        logic signed [DELTA_W-1:0] delta_mg;
    } reading_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    qea_sample_if sample_bus ();
    qea_result_if result_bus ();

    quadrature_encoder_with_acceleration_top #(
        .INTERVAL_FRAC_BITS (INTERVAL_FRAC)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_bus),
        .result_out (result_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Samples waiting to be offered, and readings the decoder owes us, oldest first
    encoder_sample_t samples_to_send[$];
    reading_t        owed_readings[$];

    // Private copy of the decoder state
    logic [1:0]  pins_seen;
    logic [31:0] last_step_ms;
    longint      avg_q;          // average interval, ms with INTERVAL_FRAC fraction bits
    longint      acc_mg;

    // Private copy of the registers
    logic [RATE_W-1:0]     rate_fast;
    logic [RATE_W-1:0]     rate_medium;
    logic [STEP_MAG_W-1:0] mg_slow;
    logic [STEP_MAG_W-1:0] mg_medium;
    logic [STEP_MAG_W-1:0] mg_fast;

    // Stimulus walk: where the simulated knob is and what it is doing
    logic [1:0]  walk_pins;
    logic [31:0] walk_ms;
    int          burst_left;
    logic        burst_up;
    int          burst_pace;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    logic long_hold_done;
    logic sample_xfer;
    encoder_sample_t outgoing;
    encoder_sample_t taken;
    reading_t        want;

    int inputs_taken;
    int readings_checked;
    int detents_seen;
    int reads_seen;
    int settings_used;
    int mismatches;

    // 2-unit clock, low first so the first rising edge is clean
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Transition table of our own: {previous A, previous B, new A, new B}.
    // Up runs 00 -> 10 -> 11 -> 01 -> 00, down runs the other way; anything else is no detent.
    function automatic dir_t detent_dir(input logic [1:0] from_pins, input logic [1:0] to_pins);
        case ({from_pins, to_pins})
            4'b0010, 4'b1011, 4'b1101, 4'b0100: return DIR_UP;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: return DIR_DOWN;
            default:                            return DIR_NONE;
        endcase
    endfunction

    // Next pin pair one detent along in the given direction
    function automatic logic [1:0] next_detent(input logic [1:0] pins, input logic up);
        case (pins)
            2'b00:   return up ? 2'b10 : 2'b01;
            2'b10:   return up ? 2'b11 : 2'b00;
            2'b11:   return up ? 2'b01 : 2'b10;
            default: return up ? 2'b00 : 2'b11;
        endcase
    endfunction

    // Rate is above threshold when 1000 ms, scaled, exceeds threshold * average
    function automatic logic faster_than(input logic [RATE_W-1:0] threshold);
        return (longint'(1000) << INTERVAL_FRAC) > longint'(threshold) * avg_q;
    endfunction

    // Work out what the decoder returns for one transferred item and advance our state
    task automatic decode_and_accumulate(input encoder_sample_t s);
        reading_t    r;
        dir_t        d;
        logic [31:0] dt;
        longint      avg_next;
        longint      mag;
        longint      step;
        r.step_mg  = '0;
        r.delta_mg = '0;
        if (s.op == OP_CONSUME)
        begin
            // Read and clear; pins and time are ignored
            r.delta_mg = acc_mg[DELTA_W-1:0];
            acc_mg = 0;
            reads_seen++;
        end
        else
        begin
            d = detent_dir(pins_seen, {s.pin_a, s.pin_b});
            pins_seen = {s.pin_a, s.pin_b};
            if (d != DIR_NONE)
            begin
                detents_seen++;
                dt = s.now_ms - last_step_ms;
                if (dt == 32'd0)
                    dt = 32'd1;
                if (dt > 32'd65535)
                    dt = 32'd65535;
                last_step_ms = s.now_ms;
                avg_next = (7 * avg_q + 3 * (longint'(dt) << INTERVAL_FRAC) + 5) / 10;
                if (avg_next > AVG_CEIL)
                    avg_next = AVG_CEIL;
                avg_q = avg_next;
                if (faster_than(rate_fast))
                    mag = mg_fast;
                else if (faster_than(rate_medium))
                    mag = mg_medium;
                else
                    mag = mg_slow;
                step = (d == DIR_UP) ? mag : -mag;
                r.step_mg = step[STEP_W-1:0];
                acc_mg = acc_mg + step;
                if (acc_mg > longint'(32'sh7FFF_FFFF))
                    acc_mg = longint'(32'sh7FFF_FFFF);
                if (acc_mg < -longint'(64'sh8000_0000))
                    acc_mg = -longint'(64'sh8000_0000);
            end
        end
        owed_readings.push_back(r);
    endtask

    task automatic push_item(input op_t op, input logic a, input logic b, input logic [31:0] t);
        encoder_sample_t s;
        s.op     = op;
        s.pin_a  = a;
        s.pin_b  = b;
        s.now_ms = t;
        samples_to_send.push_back(s);
    endtask

    // Wait until every item is out and every owed reading has come back
    task automatic wait_drained();
        while (samples_to_send.size() != 0 || sample_bus.valid || owed_readings.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Write all five registers, one per cycle, and mirror them into our copy
    task automatic set_registers(input logic [CFG_DATA_W-1:0] fast_thr,
                                 input logic [CFG_DATA_W-1:0] medium_thr,
                                 input logic [CFG_DATA_W-1:0] slow_mg,
                                 input logic [CFG_DATA_W-1:0] medium_mg,
                                 input logic [CFG_DATA_W-1:0] fast_mg);
        logic [CFG_DATA_W-1:0] vals [5];
        logic [CFG_INDEX_W-1:0] idx;
        vals = '{fast_thr, medium_thr, slow_mg, medium_mg, fast_mg};
        for (int i = 0; i < 5; i++)
        begin
            case (i)
                0:       idx = CFG_FAST_RATE;
                1:       idx = CFG_MEDIUM_RATE;
                2:       idx = CFG_SLOW_STEP;
                3:       idx = CFG_MEDIUM_STEP;
                default: idx = CFG_FAST_STEP;
            endcase
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            case (idx)
                CFG_FAST_RATE:   rate_fast   = vals[i][RATE_W-1:0];
                CFG_MEDIUM_RATE: rate_medium = vals[i][RATE_W-1:0];
                CFG_SLOW_STEP:   mg_slow     = vals[i][STEP_MAG_W-1:0];
                CFG_MEDIUM_STEP: mg_medium   = vals[i][STEP_MAG_W-1:0];
                default:         mg_fast     = vals[i][STEP_MAG_W-1:0];
            endcase
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly bursts of clean detents at one pace, plus reads, repeats and noise
    task automatic queue_random_items(input int count);
        int roll;
        int dt;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 10)
                push_item(OP_CONSUME, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
            else if (roll < 15)
            begin
                // noise: any pins at any time, so double transitions and time jumps
                walk_pins = 2'($urandom_range(3));
                walk_ms   = $urandom();
                push_item(OP_SAMPLE, walk_pins[1], walk_pins[0], walk_ms);
            end
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(3, 16);
                    burst_up   = 1'($urandom_range(1));
                    burst_pace = $urandom_range(3);
                end
                burst_left--;
                case (burst_pace)
                    0:       dt = $urandom_range(0, 40);
                    1:       dt = $urandom_range(30, 200);
                    2:       dt = $urandom_range(150, 3000);
                    default: dt = ($urandom_range(9) == 0) ? $urandom_range(60000, 80000)
                                                           : $urandom_range(0, 400);
                endcase
                walk_ms += dt;
                // now and then hold the pins where they are
                if ($urandom_range(19) != 0)
                    walk_pins = next_detent(walk_pins, burst_up);
                push_item(OP_SAMPLE, walk_pins[1], walk_pins[0], walk_ms);
            end
        end
    endtask

    // Sender: offer the next item at the falling edge, hold it until it transfers
    always @(negedge clk)
    begin
        if (rst_n && !(sample_bus.valid && !sample_xfer))
        begin
            if (samples_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                outgoing = samples_to_send.pop_front();
                sample_bus.op     <= outgoing.op;
                sample_bus.pin_a  <= outgoing.pin_a;
                sample_bus.pin_b  <= outgoing.pin_b;
                sample_bus.now_ms <= outgoing.now_ms;
                sample_bus.valid  <= 1'b1;
            end
            else
                sample_bus.valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off once enough items went in
    always @(negedge clk)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && inputs_taken >= LONG_HOLD_AT)
        begin
            result_bus.ready <= 1'b0;
            hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else
            result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Monitor: predict on each input transfer, check each result transfer
    always @(posedge clk)
    begin
        if (!rst_n)
            sample_xfer <= 1'b0;
        else
        begin
            sample_xfer <= sample_bus.valid && sample_bus.ready;
            if (sample_bus.valid && sample_bus.ready)
            begin
                taken.op     = op_t'(sample_bus.op);
                taken.pin_a  = sample_bus.pin_a;
                taken.pin_b  = sample_bus.pin_b;
                taken.now_ms = sample_bus.now_ms;
                decode_and_accumulate(taken);
                inputs_taken++;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (owed_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] unexpected result: step_mg %0d delta_mg %0d",
                                 $realtime, result_bus.step_mg, result_bus.delta_mg);
                end
                else
                begin
                    want = owed_readings.pop_front();
                    readings_checked++;
                    if (result_bus.step_mg !== want.step_mg
                        || result_bus.delta_mg !== want.delta_mg)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"[%0t] result %0d: step_mg exp %0d got %0d, ",
                                      "delta_mg exp %0d got %0d"},
                                     $realtime, readings_checked, want.step_mg,
                                     result_bus.step_mg, want.delta_mg, result_bus.delta_mg);
                    end
                end
            end
        end
    end

    // Guard against a hung handshake
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        // Known values on every input from time zero
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_FAST_RATE;
        cfg_data          = '0;
        sample_bus.valid  = 1'b0;
        sample_bus.op     = OP_SAMPLE;
        sample_bus.pin_a  = 1'b0;
        sample_bus.pin_b  = 1'b0;
        sample_bus.now_ms = '0;
        result_bus.ready  = 1'b0;

        pins_seen    = PINS_RESET;
        last_step_ms = '0;
        avg_q        = 0;
        acc_mg       = 0;
        rate_fast    = FAST_RATE_RESET;
        rate_medium  = MEDIUM_RATE_RESET;
        mg_slow      = SLOW_STEP_RESET;
        mg_medium    = MEDIUM_STEP_RESET;
        mg_fast      = FAST_STEP_RESET;

        burst_left     = 0;
        burst_up       = 1'b1;
        burst_pace     = 0;
        hold_left      = 0;
        long_hold_done = 1'b0;
        inputs_taken   = 0;
        readings_checked = 0;
        detents_seen   = 0;
        reads_seen     = 0;
        settings_used  = 1;
        mismatches     = 0;
        src_idle_pct   = 25;
        snk_idle_pct   = 54;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed walk with the reset registers; pins start at both high, times at 0
        push_item(OP_CONSUME, 1'b0, 1'b0, 32'd0);            // read of an empty accumulator
        push_item(OP_SAMPLE,  1'b1, 1'b1, 32'd0);            // no change
        push_item(OP_SAMPLE,  1'b1, 1'b0, 32'd0);            // down at the same ms: counts 1 ms
        push_item(OP_SAMPLE,  1'b0, 1'b0, 32'd0);            // down again, zero interval
        push_item(OP_SAMPLE,  1'b1, 1'b1, 32'd5);            // double transition, pins stored
        push_item(OP_SAMPLE,  1'b0, 1'b1, 32'd100000);       // up after a long interval
        push_item(OP_SAMPLE,  1'b0, 1'b0, 32'hFFFF_FFFF);    // up, interval saturates
        push_item(OP_SAMPLE,  1'b1, 1'b0, 32'd3);            // up across the time wrap, 4 ms
        push_item(OP_CONSUME, 1'b1, 1'b1, 32'hFFFF_FFFF);    // pins here must be ignored
        push_item(OP_SAMPLE,  1'b1, 1'b1, 32'd10);           // up from 10 proves pins kept
        push_item(OP_SAMPLE,  1'b1, 1'b1, 32'd11);           // same pins
        push_item(OP_SAMPLE,  1'b0, 1'b1, 32'd12);           // up
        push_item(OP_SAMPLE,  1'b1, 1'b0, 32'd13);           // double transition
        push_item(OP_SAMPLE,  1'b0, 1'b0, 32'd14);           // down
        push_item(OP_SAMPLE,  1'b0, 1'b1, 32'd15);           // down
        push_item(OP_SAMPLE,  1'b1, 1'b1, 32'd16);           // down
        push_item(OP_SAMPLE,  1'b1, 1'b0, 32'd17);           // down
        push_item(OP_SAMPLE,  1'b0, 1'b0, 32'd18);           // down
        push_item(OP_SAMPLE,  1'b1, 1'b0, 32'd60);           // up
        push_item(OP_SAMPLE,  1'b0, 1'b1, 32'd70);           // double transition
        push_item(OP_SAMPLE,  1'b0, 1'b0, 32'd200);          // up
        push_item(OP_SAMPLE,  1'b0, 1'b1, 32'd150);          // down with time going back
        push_item(OP_CONSUME, 1'b0, 1'b1, 32'd0);
        walk_pins = 2'b01;
        walk_ms   = 32'd150;

        // Random part under reset registers; the long hold-off lands in here
        queue_random_items(200);
        wait_drained();

        // Medium threshold zero makes every step at least medium; zero slow step
        src_idle_pct = 54;
        snk_idle_pct = 25;
        set_registers(17'd1000, 17'd0, 17'd0, 17'd100000, 17'd1);
        queue_random_items(130);
        wait_drained();

        // Thresholds at the top of the register: slow unless average < 1000/1023 ms, largest slow step
        src_idle_pct = 0;
        snk_idle_pct = 0;
        set_registers(17'd1023, 17'd1023, MG_ALL_ONES, 17'd7, 17'd0);
        queue_random_items(130);
        wait_drained();

        // Random thresholds around the paces the walk produces
        begin
            logic [CFG_DATA_W-1:0] thr;
            thr = 17'($urandom_range(5, 60));
            set_registers(thr, 17'($urandom_range(0, thr)), 17'($urandom_range(0, 131071)),
                          17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)));
        end
        queue_random_items(130);
        wait_drained();

        // Zero thresholds with the largest steps: every detent takes the fast step
        set_registers(17'd0, 17'd0, MG_ALL_ONES, MG_ALL_ONES, MG_ALL_ONES);
        queue_random_items(50);
        wait_drained();

        // Allow for anything still in the pipeline, then settle the verdict
        repeat (8) @(posedge clk);
        if (owed_readings.size() != 0)
        begin
            $display("%0d results never arrived", owed_readings.size());
            mismatches += owed_readings.size();
        end
        $display("Checked %0d results from %0d items: %0d detents, %0d accumulator reads,",
                 readings_checked, inputs_taken, detents_seen, reads_seen);
        $display("  %0d register settings, one long receiver stall, %0d mismatches",
                 settings_used, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== quadrature_encoder_with_acceleration_top.f =====
sv/qea_pkg.sv
sv/qea_sample_if.sv
sv/qea_result_if.sv
sv/qea_interval.sv
sv/qea_rate.sv
sv/qea_accum.sv
sv/quadrature_encoder_with_acceleration_top.sv
tb/sv/testbench.sv
